// ===== hdl/gm3d_pkg.sv =====
// Package for the 3-D gradient magnitude block: types, codes and sizes.
package gm3d_pkg;

	localparam int VOXEL_BITS     = 16;
	localparam int MAG_BITS       = 21;
	localparam int SQ_BITS        = 34;                 // sum of three squared diffs
	localparam int RAD_BITS       = SQ_BITS + 8;        // radicand, 256 * sum
	localparam int SQRT_STEPS     = RAD_BITS / 2;
	localparam int DEF_MAX_ROW    = 256;
	localparam int DEF_MAX_COLUMN = 256;
	localparam int SIZE_Z_BITS    = 16;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_SETTLE     = 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SIZE_X  = 2'd0,
		CFG_SIZE_Y  = 2'd1,
		CFG_SIZE_Z  = 2'd2,
		CFG_PADDING = 2'd3
	} gm3d_cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_ADDR,
		ST_READ,
		ST_SQRT,
		ST_DONE
	} gm3d_state_t;

	typedef struct packed {
		logic in_ready;
		logic mem_we;
		logic out_load;
	} gm3d_ctrl_t;

endpackage

// ===== hdl/gradient_magnitude_3d.sv =====
// Top level: streamed 3-D central-difference gradient magnitude over a slice ring.
//
//  channel | direction | signals                        | payload
//  --------+-----------+--------------------------------+----------------------------
//  in      | sink      | in_valid, in_ready             | voxel[15:0] signed, drain
//  out     | source    | out_valid, out_ready           | magnitude[20:0], last
//  cfg     | sink      | cfg_valid, cfg_ready           | cfg_index[1:0], cfg_data[15:0]
//
// One item at a time: an item that yields a result takes six reads of the ring's read
// port, then 21 steps of the square root.
// The output register lets the next item in while a result waits to be taken.
// Reset clears counters and control; the ring is not cleared and needs no sweep.
// Input is held off after a register write while derived sizes settle.
module gradient_magnitude_3d #(
	parameter int MAX_ROW    = gm3d_pkg::DEF_MAX_ROW,
	parameter int MAX_COLUMN = gm3d_pkg::DEF_MAX_COLUMN
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [gm3d_pkg::VOXEL_BITS-1:0] voxel,
	input  logic                                  drain,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [gm3d_pkg::MAG_BITS-1:0]         magnitude,
	output logic                                  last,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [gm3d_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [gm3d_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	localparam int SLICE_MAX  = MAX_ROW * MAX_COLUMN;
	localparam int RING_DEPTH = 2 * SLICE_MAX + 1;
	localparam int AW = $clog2(RING_DEPTH);
	localparam int MW = $clog2(RING_DEPTH + 1);
	localparam int XW = $clog2(MAX_COLUMN + 1);
	localparam int YW = $clog2(MAX_ROW + 1);
	localparam int SW = $clog2(SLICE_MAX + 1);
	localparam int ZW = gm3d_pkg::SIZE_Z_BITS;
	localparam int TW = SW + ZW;
	localparam int VB = gm3d_pkg::VOXEL_BITS;
	localparam int SQB = gm3d_pkg::SQ_BITS;
	localparam int RB = gm3d_pkg::RAD_BITS;
	localparam int SCW = $clog2(gm3d_pkg::SQRT_STEPS);

	// configuration
	logic [8:0]          size_x_q, size_y_q;
	logic [ZW-1:0]       size_z_q;
	logic signed [VB-1:0] padding_q;
	logic [1:0]          settle_q;

	logic [XW-1:0] sx;
	logic [YW-1:0] sy;
	logic [ZW-1:0] sz;
	logic [SW-1:0] slice_q;
	logic [MW-1:0] m_q;
	logic [TW-1:0] total_q;

	// stream state
	gm3d_pkg::gm3d_state_t state_q, state_d;
	gm3d_pkg::gm3d_ctrl_t  ctrl;
	logic [TW-1:0] recv_q, emit_q;
	logic [AW-1:0] wp_q, ep_q;
	logic [XW-1:0] ex_q;
	logic [YW-1:0] ey_q;
	logic [ZW-1:0] ez_q;

	logic signed [VB-1:0] voxel_s1;
	logic                 drain_s1;
	logic                 go;

	// ring memory
	logic signed [VB-1:0] ring [RING_DEPTH];
	logic signed [VB-1:0] rdata_q;
	logic [AW-1:0]        rd_addr;

	// neighbour fetch and sum
	logic [AW-1:0]        addr_q [6];
	logic [2:0]           use_q;
	logic                 last_q;
	logic [2:0]           rd_cnt_q;
	logic signed [VB-1:0] lo_q, hi_q;
	logic [SQB-1:0]       sum_q, sum_d;

	// square root
	logic [RB-1:0]  rad_q, root_q, bit_q;
	logic [SCW-1:0] sq_cnt_q;

	logic out_valid_q, out_last_q;
	logic [gm3d_pkg::MAG_BITS-1:0] out_mag_q;

	assign cfg_ready = 1'b1;

	// clamped sizes
	always_comb begin
		if (size_x_q == '0)
			sx = XW'(1);
		else if (32'(size_x_q) > MAX_COLUMN)
			sx = XW'(MAX_COLUMN);
		else
			sx = XW'(size_x_q);
		if (size_y_q == '0)
			sy = YW'(1);
		else if (32'(size_y_q) > MAX_ROW)
			sy = YW'(MAX_ROW);
		else
			sy = YW'(size_y_q);
		sz = (size_z_q == '0) ? ZW'(1) : size_z_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q  <= 9'd256;
			size_y_q  <= 9'd256;
			size_z_q  <= ZW'(256);
			padding_q <= {1'b1, {(VB-1){1'b0}}};
			settle_q  <= '0;
		end else begin
			if (cfg_valid) begin
				settle_q <= 2'(gm3d_pkg::CFG_SETTLE);
				case (gm3d_pkg::gm3d_cfg_idx_t'(cfg_index))
					gm3d_pkg::CFG_SIZE_X:  size_x_q  <= cfg_data[8:0];
					gm3d_pkg::CFG_SIZE_Y:  size_y_q  <= cfg_data[8:0];
					gm3d_pkg::CFG_SIZE_Z:  size_z_q  <= cfg_data[ZW-1:0];
					gm3d_pkg::CFG_PADDING: padding_q <= cfg_data[VB-1:0];
					default: ;
				endcase
			end else if (settle_q != '0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	// derived sizes: slice and total each use a multiplier, m is 2 * slice + 1
	always_ff @(posedge clk) begin
		slice_q <= SW'(sx) * SW'(sy);
		m_q     <= MW'({slice_q, 1'b1});
		total_q <= TW'(slice_q) * TW'(sz);
	end

	// decision for the current item
	always_comb begin
		logic flush;
		logic [TW:0] pend;
		flush = drain_s1 || (recv_q >= total_q);
		pend  = {1'b0, recv_q} + (TW+1)'(1) - {1'b0, emit_q};
		if (flush)
			go = emit_q < recv_q;
		else
			go = pend > (TW+1)'(slice_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gm3d_pkg::ST_IDLE:   if (in_valid && ctrl.in_ready) state_d = gm3d_pkg::ST_DECIDE;
			gm3d_pkg::ST_DECIDE: state_d = go ? gm3d_pkg::ST_ADDR : gm3d_pkg::ST_IDLE;
			gm3d_pkg::ST_ADDR:   state_d = gm3d_pkg::ST_READ;
			gm3d_pkg::ST_READ:   if (rd_cnt_q == 3'd7) state_d = gm3d_pkg::ST_SQRT;
			gm3d_pkg::ST_SQRT:
				if (sq_cnt_q == SCW'(gm3d_pkg::SQRT_STEPS - 1)) state_d = gm3d_pkg::ST_DONE;
			gm3d_pkg::ST_DONE:   if (!out_valid_q || out_ready) state_d = gm3d_pkg::ST_IDLE;
			default:             state_d = gm3d_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		ctrl = '0;
		case (state_q)
			gm3d_pkg::ST_IDLE:   ctrl.in_ready = (settle_q == '0);
			gm3d_pkg::ST_DECIDE: ctrl.mem_we = !(drain_s1 || (recv_q >= total_q));
			gm3d_pkg::ST_DONE:   ctrl.out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign in_ready = ctrl.in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= gm3d_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (in_valid && ctrl.in_ready) begin
			voxel_s1 <= voxel;
			drain_s1 <= drain;
		end
	end

	// ring: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctrl.mem_we)
			ring[wp_q] <= voxel_s1;
		rdata_q <= ring[rd_addr];
	end

	always_comb begin
		case (rd_cnt_q)
			3'd0:    rd_addr = addr_q[0];
			3'd1:    rd_addr = addr_q[1];
			3'd2:    rd_addr = addr_q[2];
			3'd3:    rd_addr = addr_q[3];
			3'd4:    rd_addr = addr_q[4];
			3'd5:    rd_addr = addr_q[5];
			default: rd_addr = '0;
		endcase
	end

	// counters, pointers and emit coordinates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_q <= '0;
			emit_q <= '0;
			wp_q   <= '0;
			ep_q   <= '0;
			ex_q   <= '0;
			ey_q   <= '0;
			ez_q   <= '0;
		end else begin
			if (ctrl.mem_we) begin
				recv_q <= recv_q + TW'(1);
				wp_q   <= ((MW'(wp_q) + MW'(1)) == m_q) ? '0 : wp_q + AW'(1);
			end
			if (state_q == gm3d_pkg::ST_ADDR) begin
				if ({1'b0, emit_q} + (TW+1)'(1) >= {1'b0, total_q}) begin
					recv_q <= '0;
					emit_q <= '0;
					wp_q   <= '0;
					ep_q   <= '0;
					ex_q   <= '0;
					ey_q   <= '0;
					ez_q   <= '0;
				end else begin
					emit_q <= emit_q + TW'(1);
					ep_q   <= ((MW'(ep_q) + MW'(1)) == m_q) ? '0 : ep_q + AW'(1);
					if ((XW+1)'(ex_q) + (XW+1)'(1) >= (XW+1)'(sx)) begin
						ex_q <= '0;
						if ((YW+1)'(ey_q) + (YW+1)'(1) >= (YW+1)'(sy)) begin
							ey_q <= '0;
							ez_q <= ez_q + ZW'(1);
						end else begin
							ey_q <= ey_q + YW'(1);
						end
					end else begin
						ex_q <= ex_q + XW'(1);
					end
				end
			end
		end
	end

	// neighbour addresses and axis enables
	always_ff @(posedge clk) begin
		if (state_q == gm3d_pkg::ST_ADDR) begin
			for (int a = 0; a < 3; a++) begin
				logic [MW:0] off, ep, m, up;
				logic in_vol;
				off = (a == 0) ? (MW+1)'(1) : (a == 1) ? (MW+1)'(sx) : (MW+1)'(slice_q);
				ep  = (MW+1)'(ep_q);
				m   = (MW+1)'(m_q);
				up  = ep + off;
				addr_q[2*a]   <= AW'((ep >= off) ? ep - off : ep + m - off);
				addr_q[2*a+1] <= AW'((up >= m) ? up - m : up);
				case (a)
					0: in_vol = (ex_q != '0) && ((XW+1)'(ex_q) + (XW+1)'(1) < (XW+1)'(sx));
					1: in_vol = (ey_q != '0) && ((YW+1)'(ey_q) + (YW+1)'(1) < (YW+1)'(sy));
					default: in_vol = (ez_q != '0) && ((ZW+1)'(ez_q) + (ZW+1)'(1) < (ZW+1)'(sz));
				endcase
				use_q[a] <= in_vol && (({1'b0, emit_q} + (TW+1)'(off)) < {1'b0, recv_q});
			end
			last_q <= {1'b0, emit_q} + (TW+1)'(1) >= {1'b0, total_q};
		end
	end

	// reads in flight: lo of an axis lands at odd counts, hi at even, summed at the odd count after its hi
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_cnt_q <= '0;
		else if (state_q == gm3d_pkg::ST_READ)
			rd_cnt_q <= rd_cnt_q + 3'd1;
		else
			rd_cnt_q <= '0;
	end

	// running sum including the axis pair that completes this cycle
	always_comb begin
		logic [1:0] ax;
		logic signed [VB:0] d;
		logic [VB-1:0] ad;
		ax = 2'((rd_cnt_q - 3'd3) >> 1);
		d  = (VB+1)'(lo_q) - (VB+1)'(hi_q);
		ad = VB'(d[VB] ? -d : d);
		sum_d = sum_q;
		if (state_q == gm3d_pkg::ST_READ && rd_cnt_q[0] && rd_cnt_q >= 3'd3 && use_q[ax]
		    && lo_q > padding_q && hi_q > padding_q)
			sum_d = sum_q + SQB'(ad) * SQB'(ad);
	end

	always_ff @(posedge clk) begin
		if (state_q == gm3d_pkg::ST_ADDR)
			sum_q <= '0;
		else if (state_q == gm3d_pkg::ST_READ) begin
			if (rd_cnt_q[0])
				lo_q <= rdata_q;
			else
				hi_q <= rdata_q;
			sum_q <= sum_d;
		end
	end

	// square root, one result bit a cycle
	always_ff @(posedge clk) begin
		if (state_q == gm3d_pkg::ST_READ) begin
			rad_q    <= {sum_d, 8'd0};
			root_q   <= '0;
			bit_q    <= RB'(1) << (RB - 2);
			sq_cnt_q <= '0;
		end else if (state_q == gm3d_pkg::ST_SQRT) begin
			if (rad_q >= root_q + bit_q) begin
				rad_q  <= rad_q - (root_q + bit_q);
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q    <= bit_q >> 2;
			sq_cnt_q <= sq_cnt_q + SCW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctrl.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			out_mag_q  <= root_q[gm3d_pkg::MAG_BITS-1:0];
			out_last_q <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign magnitude = out_mag_q;
	assign last      = out_last_q;

	// checks
	a_sqrt_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gm3d_pkg::ST_SQRT |-> $onehot(bit_q))
		else $error("square root step bit not one-hot");

	a_accept_decides: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == gm3d_pkg::ST_DECIDE)
		else $error("accepted transaction not decided next cycle");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gm3d_pkg::ST_DONE && (!out_valid || out_ready) |=> out_valid)
		else $error("finished result not presented");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == gm3d_pkg::ST_IDLE && settle_q == '0)
		else $error("input taken while busy or settling");

endmodule

// ===== bench/tb_gradient_magnitude_3d.sv =====
// Testbench for gradient_magnitude_3d: directed table, then random volumes checked against a predictor.
`timescale 1ns / 100ps

module tb_gradient_magnitude_3d;

	localparam int RING_SIZE = 2 * gm3d_pkg::DEF_MAX_ROW * gm3d_pkg::DEF_MAX_COLUMN + 1;
	localparam int STALL_LIMIT = 3000;
	localparam int MB = gm3d_pkg::MAG_BITS;
	localparam int IB = gm3d_pkg::CFG_IDX_BITS;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] voxel;
	logic               drain;
	logic               out_valid;
	logic               out_ready;
	logic [MB-1:0]      magnitude;
	logic               last;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [IB-1:0]      cfg_index;
	logic [15:0]        cfg_data;

	typedef struct {
		logic [MB-1:0] mag;
		logic          lst;
	} grad_t;

	typedef struct {
		bit                      is_cfg;
		gm3d_pkg::gm3d_cfg_idx_t idx;
		logic [15:0]             data;
		logic signed [15:0]      vox;
		bit                      drn;
		bit                      known;
		logic [MB-1:0]           mag;
		bit                      lst;
	} row_t;

	// directed volumes: 3x1x1 extremes, early drain with missing neighbour, 1x2x1 high padding
	row_t dir_rows [27] = '{
		'{0, gm3d_pkg::CFG_SIZE_X, 16'd0, 16'sd0, 1, 0, 21'd0, 0},
		'{1, gm3d_pkg::CFG_SIZE_X, 16'd3, 16'sd0, 0, 0, 21'd0, 0},
		'{1, gm3d_pkg::CFG_SIZE_Y, 16'd1, 16'sd0, 0, 0, 21'd0, 0},
		'{1, gm3d_pkg::CFG_SIZE_Z, 16'd1, 16'sd0, 0, 0, 21'd0, 0},
		'{0, gm3d_pkg::CFG_SIZE_X, 16'd0, 16'sd32767, 0, 0, 21'd0, 0},
		'{0, gm3d_pkg::CFG_SIZE_X, 16'd0, 16'sd0, 0, 0, 21'd0, 0},
		'{0, gm3d_pkg::CFG_SIZE_X, 16'd0, -16'sd32767, 0, 0, 21'd0, 0},
		'{0, gm3d_pkg::CFG_SIZE_X, 16'd0, 16'sd0, 1, 1, 21'd0, 0},
		'{0, gm3d_pkg::CFG_SIZE_X, 16'd0, 16'sd0, 1, 1, 21'd1048544, 0},
		'{0, gm3d_pkg::CFG_SIZE_X, 16'd0, 16'sd5, 0, 1, 21'd0, 1},
		'{0, gm3d_pkg::CFG_SIZE_X, 16'd0, 16'sd100, 0, 0, 21'd0, 0},
		'{0, gm3d_pkg::CFG_SIZE_X, 16'd0, 16'sd200, 0, 0, 21'd0, 0},
		'{0, gm3d_pkg::CFG_SIZE_X, 16'd0, 16'sd0, 1, 0, 21'd0, 0},
		'{0, gm3d_pkg::CFG_SIZE_X, 16'd0, 16'sd0, 1, 0, 21'd0, 0},
		'{0, gm3d_pkg::CFG_SIZE_X, 16'd0, -16'sd5, 0, 0, 21'd0, 0},
		'{0, gm3d_pkg::CFG_SIZE_X, 16'd0, 16'sd0, 1, 0, 21'd0, 0},
		'{1, gm3d_pkg::CFG_PADDING, 16'h7fff, 16'sd0, 0, 0, 21'd0, 0},
		'{1, gm3d_pkg::CFG_SIZE_X, 16'd0, 16'sd0, 0, 0, 21'd0, 0},
		'{1, gm3d_pkg::CFG_SIZE_Z, 16'd0, 16'sd0, 0, 0, 21'd0, 0},
		'{1, gm3d_pkg::CFG_SIZE_Y, 16'd2, 16'sd0, 0, 0, 21'd0, 0},
		'{0, gm3d_pkg::CFG_SIZE_X, 16'd0, -16'sd1, 0, 0, 21'd0, 0},
		'{0, gm3d_pkg::CFG_SIZE_X, 16'd0, 16'sd1, 0, 0, 21'd0, 0},
		'{0, gm3d_pkg::CFG_SIZE_X, 16'd0, 16'sd0, 1, 1, 21'd0, 0},
		'{0, gm3d_pkg::CFG_SIZE_X, 16'd0, 16'sd0, 1, 1, 21'd0, 1},
		'{1, gm3d_pkg::CFG_SIZE_Z, 16'hffff, 16'sd0, 0, 0, 21'd0, 0},
		'{1, gm3d_pkg::CFG_SIZE_X, 16'h01ff, 16'sd0, 0, 0, 21'd0, 0},
		'{1, gm3d_pkg::CFG_SIZE_Y, 16'h01ff, 16'sd0, 0, 0, 21'd0, 0}
	};

	// predictor state
	logic signed [15:0] vox_ring [RING_SIZE];
	int unsigned        rcv_cnt, emt_cnt, ex, ey, ez;
	logic [8:0]         reg_x, reg_y;
	logic [15:0]        reg_z;
	logic signed [15:0] reg_pad;

	grad_t       grad_q[$];
	int          err_cnt;
	int          idle_cnt;
	bit          src_gaps, sink_stalls;
	int unsigned gap_pct;
	int unsigned item_cnt;

	gradient_magnitude_3d dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .voxel(voxel), .drain(drain),
		.out_valid(out_valid), .out_ready(out_ready), .magnitude(magnitude), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic longint unsigned sqrt_floor(longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic longint unsigned diff_sq(bit ok, longint lo, longint hi, longint m);
		longint a, b;
		if (!ok || hi >= rcv_cnt)
			return 0;
		a = vox_ring[lo % m];
		b = vox_ring[hi % m];
		if (!(a > reg_pad) || !(b > reg_pad))
			return 0;
		return (a - b) * (a - b);
	endfunction

	function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
		if (v < 1)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	// advance the gradient predictor by one input transaction
	function automatic bit grad_predict(logic signed [15:0] v, bit drn, output grad_t g);
		longint sx, sy, sz, slice, total, m, p;
		longint unsigned s;
		bit flush, go;
		sx = clamp_size(reg_x, gm3d_pkg::DEF_MAX_COLUMN);
		sy = clamp_size(reg_y, gm3d_pkg::DEF_MAX_ROW);
		sz = clamp_size(reg_z, 65535);
		slice = sx * sy;
		total = slice * sz;
		m = 2 * slice + 1;
		flush = drn || (rcv_cnt >= total);
		if (!flush) begin
			vox_ring[rcv_cnt % m] = v;
			rcv_cnt++;
			go = (rcv_cnt - emt_cnt) > slice;
		end else begin
			go = emt_cnt < rcv_cnt;
		end
		if (!go)
			return 0;
		p = emt_cnt;
		s = diff_sq(ex > 0 && ex + 1 < sx, p - 1, p + 1, m);
		s += diff_sq(ey > 0 && ey + 1 < sy, p - sx, p + sx, m);
		s += diff_sq(ez > 0 && ez + 1 < sz, p - slice, p + slice, m);
		g.mag = MB'(sqrt_floor(s << 8));
		g.lst = (p + 1 >= total);
		if (g.lst) begin
			rcv_cnt = 0; emt_cnt = 0; ex = 0; ey = 0; ez = 0;
		end else begin
			emt_cnt++;
			ex++;
			if (ex >= sx) begin
				ex = 0;
				ey++;
				if (ey >= sy) begin
					ey = 0;
					ez = (ez + 1) & 16'hffff;
				end
			end
		end
		return 1;
	endfunction

	task automatic send_item(logic signed [15:0] v, bit drn, bit known = 0, grad_t kg = '{0, 0});
		grad_t g;
		if (src_gaps && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		in_valid <= 1'b1;
		voxel    <= v;
		drain    <= drn;
		do @(posedge clk); while (!in_ready);
		item_cnt++;
		if (grad_predict(v, drn, g))
			grad_q.push_back(known ? kg : g);
		else if (known)
			grad_q.push_back(kg);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (grad_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(gm3d_pkg::gm3d_cfg_idx_t idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			gm3d_pkg::CFG_SIZE_X: reg_x = data[8:0];
			gm3d_pkg::CFG_SIZE_Y: reg_y = data[8:0];
			gm3d_pkg::CFG_SIZE_Z: reg_z = data;
			default:              reg_pad = data;
		endcase
	endtask

	function automatic logic signed [15:0] rand_voxel();
		case ($urandom_range(7))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return -16'sd32767;
			default: return 16'($urandom);
		endcase
	endfunction

	always @(posedge clk) begin
		out_ready <= sink_stalls ? ($urandom_range(99) >= gap_pct) : 1'b1;
	end

	// result checker
	always @(posedge clk) begin
		grad_t e;
		if (arst_n && out_valid && out_ready) begin
			if (grad_q.size() == 0) begin
				$error("unexpected result magnitude=%0d last=%0b", magnitude, last);
				err_cnt++;
			end else begin
				e = grad_q.pop_front();
				if (magnitude !== e.mag) begin
					$error("magnitude: expected %0d, got %0d", e.mag, magnitude);
					err_cnt++;
				end
				if (last !== e.lst) begin
					$error("last: expected %0b, got %0b", e.lst, last);
					err_cnt++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned sx, sy, sz, total, sent;
		grad_t kg;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		voxel     <= '0;
		drain     <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= gm3d_pkg::CFG_SIZE_X;
		cfg_data  <= '0;
		out_ready <= 1'b1;
		idle_cnt  = 0;
		err_cnt   = 0;
		item_cnt  = 0;
		src_gaps  = 0;
		sink_stalls = 0;
		gap_pct   = 46;
		rcv_cnt = 0; emt_cnt = 0; ex = 0; ey = 0; ez = 0;
		reg_x = 9'd256; reg_y = 9'd256; reg_z = 16'd256; reg_pad = -16'sd32768;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				wait_idle();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				kg.mag = dir_rows[i].mag;
				kg.lst = dir_rows[i].lst;
				send_item(dir_rows[i].vox, dir_rows[i].drn, dir_rows[i].known, kg);
			end
		end

		for (int ph = 0; ph < 4; ph++) begin
			src_gaps    = (ph == 1) || (ph == 3);
			sink_stalls = (ph == 2) || (ph == 3);
			gap_pct     = (ph == 3) ? 11 : 46;
			sent = item_cnt;
			while (item_cnt - sent < 80) begin
				wait_idle();
				if (ph == 0 && item_cnt == sent) begin
					// one full-width row
					sx = 256; sy = 1; sz = 1;
				end else begin
					sx = $urandom_range(1, 8); sy = $urandom_range(1, 6);
					sz = $urandom_range(1, 5);
				end
				// unused upper bits of the X and Y size registers get random junk now and then
				write_reg(gm3d_pkg::CFG_SIZE_X,
				          16'(sx | ($urandom_range(3) == 0 ? ($urandom & 16'hfe00) : 0)));
				write_reg(gm3d_pkg::CFG_SIZE_Y,
				          16'(sy | ($urandom_range(3) == 0 ? ($urandom & 16'hfe00) : 0)));
				write_reg(gm3d_pkg::CFG_SIZE_Z, 16'(sz));
				case ($urandom_range(3))
					0: write_reg(gm3d_pkg::CFG_PADDING, 16'h8000);
					1: write_reg(gm3d_pkg::CFG_PADDING, 16'h7fff);
					default: write_reg(gm3d_pkg::CFG_PADDING, 16'($urandom));
				endcase
				if ($urandom_range(9) == 0)
					send_item(rand_voxel(), 1'b1);
				total = sx * sy * sz;
				for (int n = 0; n < total; n++) begin
					if ($urandom_range(9) == 0)
						send_item(rand_voxel(), 1'b1);
					send_item(rand_voxel(), 1'b0);
				end
				// flush: extra voxels act as drains too
				while (rcv_cnt != 0)
					send_item(rand_voxel(), $urandom_range(3) != 0);
			end
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/gm3d_pkg.sv
hdl/gradient_magnitude_3d.sv
bench/tb_gradient_magnitude_3d.sv
